// ===== rtl/pbu_pkg.sv =====
// Shared types, widths and codes for the palette bit-packed unpacker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package pbu_pkg;

  // Default sizing for the top-level parameters
  localparam int DEF_PALETTE_DEPTH = 256;
  localparam int DEF_PACKED_DEPTH  = 16384;
  localparam int DEF_SIDE          = 16;

  // Field widths fixed by the item and register layout
  localparam int FUNC_W   = 2;
  localparam int ENTRY_W  = 14;
  localparam int DATA_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int BPE_W    = 6;
  localparam int COUNT_W  = 9;
  localparam int SIZE_W   = 15;
  localparam int LOC_W    = 4;
  localparam int STATUS_W = 2;
  localparam int PIDX_W   = 32;

  // Gather geometry: five bytes cover any 32-bit index at any bit offset
  localparam int GATHER_BYTES = 5;
  localparam int MAX_WIDTH    = 32;
  localparam int STEP_W       = 3;
  localparam int POS_W        = ENTRY_W + BPE_W;  // entry * clamped width
  localparam int BASE_W       = POS_W - 3;        // byte address of first byte
  localparam int LIM_W        = 18;               // byte address plus step, and limits

  // APB register file
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_BPE   = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_SIZE  = 2'd2;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_PAL_WR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BYTE_WR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_FINISH
  } top_state_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_POS,
    G_FETCH,
    G_EXTRACT
  } gth_state_t;

  // Requests from the top level into the gather unit
  typedef struct packed {
    logic                 start;
    logic                 wr_en;
    logic [ENTRY_W-1:0]   wr_addr;
    logic [BYTE_W-1:0]    wr_data;
  } gth_req_t;

  // Completion from the gather unit
  typedef struct packed {
    logic              done;
    logic [PIDX_W-1:0] pidx;
  } gth_stat_t;

endpackage

// ===== rtl/pbu_gather.sv =====
// Packed byte store and the byte-serial gather/extract unit.
// Depends on pbu_pkg.
`timescale 1ns / 1ps

module pbu_gather #(
  parameter int PACKED_DEPTH = pbu_pkg::DEF_PACKED_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pbu_pkg::gth_req_t           req,
  input  logic [pbu_pkg::ENTRY_W-1:0] entry,
  input  logic [pbu_pkg::BPE_W-1:0]   bits_per_entry,
  input  logic [pbu_pkg::SIZE_W-1:0]  packed_size,
  output pbu_pkg::gth_stat_t          stat
);
  import pbu_pkg::*;

  localparam int PK_AW = $clog2(PACKED_DEPTH);

  logic [BYTE_W-1:0] mem [PACKED_DEPTH];

  gth_state_t state, state_next;

  logic [ENTRY_W-1:0]            entry_r;
  logic [BPE_W-1:0]              width_r;
  logic [LIM_W-1:0]              limit_r;
  logic                          zero_r;
  logic [POS_W-1:0]              bit_pos;
  logic [STEP_W-1:0]             step;
  logic [BYTE_W-1:0]             rd_data;
  logic                          lane_ok;
  logic [GATHER_BYTES-1:0][BYTE_W-1:0] acc;
  logic                          done;
  logic [PIDX_W-1:0]             pidx;

  logic [BPE_W-1:0]              width_clamp;
  logic [LIM_W-1:0]              limit_clamp;
  logic [LIM_W-1:0]              rd_addr;
  logic                          rd_ok;
  logic [GATHER_BYTES*BYTE_W-1:0] shifted;
  logic [PIDX_W-1:0]             mask;

  // Clamp the configuration to the supported range
  assign width_clamp = (bits_per_entry > BPE_W'(MAX_WIDTH)) ? BPE_W'(MAX_WIDTH)
                                                            : bits_per_entry;
  assign limit_clamp = (LIM_W'(packed_size) > LIM_W'(PACKED_DEPTH)) ? LIM_W'(PACKED_DEPTH)
                                                                    : LIM_W'(packed_size);

  // Byte address of the current fetch step and its range check
  assign rd_addr = LIM_W'(bit_pos[POS_W-1:3]) + LIM_W'(step);
  assign rd_ok   = rd_addr < limit_r;

  // Bit-offset shift and width mask of the gathered bytes
  assign shifted = acc >> bit_pos[2:0];
  assign mask    = (width_r >= BPE_W'(MAX_WIDTH)) ? '1
                                                  : ((PIDX_W'(1) << width_r[4:0]) - PIDX_W'(1));

  // Packed store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[PK_AW'(req.wr_addr)] <= req.wr_data;
    end
    rd_data <= mem[rd_addr[PK_AW-1:0]];
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      G_IDLE:    if (req.start) state_next = G_POS;
      G_POS:     state_next = G_FETCH;
      G_FETCH:   if (step == STEP_W'(GATHER_BYTES)) state_next = G_EXTRACT;
      G_EXTRACT: state_next = G_IDLE;
      default:   state_next = G_IDLE;
    endcase
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == G_EXTRACT);
      if (state == G_FETCH && step != STEP_W'(GATHER_BYTES)) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  // Datapath: latch request, bit position, byte lanes, extracted index
  always_ff @(posedge clk) begin
    if (state == G_IDLE && req.start) begin
      entry_r <= entry;
      width_r <= width_clamp;
      limit_r <= limit_clamp;
      zero_r  <= (width_clamp == '0) || (limit_clamp == '0);
    end
    if (state == G_POS) begin
      bit_pos <= POS_W'(entry_r) * POS_W'(width_r);
    end
    if (state == G_FETCH) begin
      lane_ok <= rd_ok;
      for (int j = 0; j < GATHER_BYTES; j++) begin
        if (step == STEP_W'(j + 1)) begin
          acc[j] <= lane_ok ? rd_data : '0;
        end
      end
    end
    if (state == G_EXTRACT) begin
      pidx <= zero_r ? '0 : (shifted[PIDX_W-1:0] & mask);
    end
  end

  assign stat.done = done;
  assign stat.pidx = pidx;

endmodule

// ===== rtl/pbu_split.sv =====
// Splits an entry index into x/z/y coordinates by reciprocal multiplication.
// Depends on pbu_pkg.
`timescale 1ns / 1ps

module pbu_split #(
  parameter int SIDE = pbu_pkg::DEF_SIDE
) (
  input  logic                        clk,
  input  logic                        start,
  input  logic [pbu_pkg::ENTRY_W-1:0] entry,
  output logic [pbu_pkg::LOC_W-1:0]   local_x,
  output logic [pbu_pkg::LOC_W-1:0]   local_z,
  output logic [pbu_pkg::LOC_W-1:0]   local_y
);
  import pbu_pkg::*;

  // ceil(2^32 / d) gives an exact floor quotient for 14-bit dividends
  localparam logic [63:0] RECIP_SIDE =
    ((64'd1 << 32) + 64'(SIDE) - 64'd1) / 64'(SIDE);
  localparam logic [63:0] RECIP_PLANE =
    ((64'd1 << 32) + 64'(SIDE * SIDE) - 64'd1) / 64'(SIDE * SIDE);
  localparam int PROD_W = ENTRY_W + 32;

  logic [ENTRY_W-1:0] entry_r;
  logic [ENTRY_W-1:0] q_side;
  logic [ENTRY_W-1:0] q_plane;
  logic [PROD_W-1:0]  prod_side;
  logic [PROD_W-1:0]  prod_plane;
  logic [ENTRY_W-1:0] rem_x;
  logic [ENTRY_W-1:0] rem_z;

  assign prod_side  = PROD_W'(entry) * PROD_W'(RECIP_SIDE[31:0]);
  assign prod_plane = PROD_W'(entry) * PROD_W'(RECIP_PLANE[31:0]);

  // Quotients registered before the back-multiply
  always_ff @(posedge clk) begin
    if (start) begin
      entry_r <= entry;
      q_side  <= prod_side[PROD_W-1:32];
      q_plane <= prod_plane[PROD_W-1:32];
    end
  end

  // Remainders by constant multiply and subtract
  assign rem_x = entry_r - ENTRY_W'(q_side * ENTRY_W'(SIDE));
  assign rem_z = q_side - ENTRY_W'(q_plane * ENTRY_W'(SIDE));

  assign local_x = rem_x[LOC_W-1:0];
  assign local_z = rem_z[LOC_W-1:0];
  assign local_y = q_plane[LOC_W-1:0];

endmodule

// ===== rtl/palette_bitpacked_unpacker.sv =====
// Palette bit-packed unpacker: input/output word channels with valid/stall,
// APB register file (bits_per_entry, palette_count, packed_size).
// A word carries func/address/data. A palette write (func 0) or packed byte
// write (func 1) is taken while idle and gives no result; func 3 is dropped.
// A read (func 2) gives one result word: state_id, local_x/z/y and status.
// A read goes through the gather unit, which steps through five packed bytes
// one per cycle on the single read port of the packed store, then extracts
// the index and looks up the palette. From acceptance until the result is
// loaded into the output register in_stall is high, so a read is finished
// before the next item is taken; writes are taken one per cycle between reads.
// The output register holds a finished word while out_stall is high; the
// next item may be accepted meanwhile, and a following read waits in its
// last step until the register is free.
// Reset (rst, synchronous) clears the config registers, the sequencers and
// out_valid. Store contents are not cleared and must be written before use.
// Depends on pbu_pkg, pbu_gather and pbu_split.
`timescale 1ns / 1ps

module palette_bitpacked_unpacker #(
  parameter int PALETTE_DEPTH = pbu_pkg::DEF_PALETTE_DEPTH,
  parameter int PACKED_DEPTH  = pbu_pkg::DEF_PACKED_DEPTH,
  parameter int SIDE          = pbu_pkg::DEF_SIDE
) (
  input  logic                         clk,
  input  logic                         rst,
  // input word channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pbu_pkg::FUNC_W-1:0]   func,
  input  logic [pbu_pkg::ENTRY_W-1:0]  address,
  input  logic [pbu_pkg::DATA_W-1:0]   data,
  // output word channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pbu_pkg::DATA_W-1:0]   state_id,
  output logic [pbu_pkg::LOC_W-1:0]    local_x,
  output logic [pbu_pkg::LOC_W-1:0]    local_z,
  output logic [pbu_pkg::LOC_W-1:0]    local_y,
  output logic [pbu_pkg::STATUS_W-1:0] status,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbu_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbu_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbu_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import pbu_pkg::*;

  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  logic [DATA_W-1:0] palette [PALETTE_DEPTH];

  top_state_t state, state_next;

  logic [BPE_W-1:0]    bits_per_entry;
  logic [COUNT_W-1:0]  palette_count;
  logic [SIZE_W-1:0]   packed_size;

  logic                in_take;
  logic                out_take;
  logic                out_load;
  logic                cfg_wr;
  gth_req_t            gth_req;
  gth_stat_t           gth_stat;
  logic [PIDX_W-1:0]   count_clamp;
  logic [STATUS_W-1:0] status_calc;
  logic [STATUS_W-1:0] status_r;
  logic [DATA_W-1:0]   pal_rd;
  logic [LOC_W-1:0]    split_x;
  logic [LOC_W-1:0]    split_z;
  logic [LOC_W-1:0]    split_y;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_entry <= '0;
      palette_count  <= '0;
      packed_size    <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BPE:   bits_per_entry <= pwdata[BPE_W-1:0];
        REG_COUNT: palette_count  <= pwdata[COUNT_W-1:0];
        REG_SIZE:  packed_size    <= pwdata[SIZE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BPE:   prdata = PDATA_W'(bits_per_entry);
      REG_COUNT: prdata = PDATA_W'(palette_count);
      REG_SIZE:  prdata = PDATA_W'(packed_size);
      default:   prdata = '0;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    in_stall          = 1'b1;
    out_load          = 1'b0;
    gth_req.start     = 1'b0;
    gth_req.wr_en     = 1'b0;
    gth_req.wr_addr   = address;
    gth_req.wr_data   = data[BYTE_W-1:0];
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (func == FUNC_READ) begin
            gth_req.start = 1'b1;
            state_next    = S_GATHER;
          end else if (func == FUNC_BYTE_WR) begin
            gth_req.wr_en = LIM_W'(address) < LIM_W'(PACKED_DEPTH);
          end
        end
      end
      S_GATHER: begin
        if (gth_stat.done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Status of the looked-up index
  assign count_clamp = (PIDX_W'(palette_count) > PIDX_W'(PALETTE_DEPTH))
                       ? PIDX_W'(PALETTE_DEPTH) : PIDX_W'(palette_count);

  always_comb begin
    if (count_clamp == '0) begin
      status_calc = ST_EMPTY;
    end else if (gth_stat.pidx >= count_clamp) begin
      status_calc = ST_RANGE;
    end else begin
      status_calc = ST_OK;
    end
  end

  // Palette store: write on accepted palette word, read when index arrives
  always_ff @(posedge clk) begin
    if (in_take && func == FUNC_PAL_WR && address < ENTRY_W'(PALETTE_DEPTH)) begin
      palette[address[PAL_AW-1:0]] <= data;
    end
    if (state == S_GATHER && gth_stat.done) begin
      pal_rd   <= palette[gth_stat.pidx[PAL_AW-1:0]];
      status_r <= status_calc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      state_id <= (status_r == ST_OK) ? pal_rd : '0;
      local_x  <= split_x;
      local_z  <= split_z;
      local_y  <= split_y;
      status   <= status_r;
    end
  end

  pbu_gather #(
    .PACKED_DEPTH (PACKED_DEPTH)
  ) u_gather (
    .clk            (clk),
    .rst            (rst),
    .req            (gth_req),
    .entry          (address),
    .bits_per_entry (bits_per_entry),
    .packed_size    (packed_size),
    .stat           (gth_stat)
  );

  pbu_split #(
    .SIDE (SIDE)
  ) u_split (
    .clk     (clk),
    .start   (gth_req.start),
    .entry   (address),
    .local_x (split_x),
    .local_z (split_z),
    .local_y (split_y)
  );

`ifndef SYNTH
  // The gather unit only finishes while the sequencer waits for it
  a_done_in_gather: assert property (@(posedge clk) disable iff (rst)
    gth_stat.done |-> state == S_GATHER)
    else $error("gather completion outside gather wait");

  // An accepted read closes the input channel in the next cycle
  a_read_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_take && func == FUNC_READ) |=> in_stall)
    else $error("input not stalled after read accept");

  // Error results carry a zero state id
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> state_id == '0)
    else $error("nonzero state id on error result");
`endif

endmodule
